>>> design/sde_pkg.sv
`default_nettype none
package sde_pkg;

  localparam int MAX_HALF_WINDOW = 15;
  localparam int MAX_SAMPLES     = 4096;
  localparam int CNT_W           = 13;
  localparam int IDX_W           = 12;
  localparam int WAVE_DEPTH      = 64;
  localparam int INT_DEPTH       = 32;
  localparam int WAVE_AW         = 6;
  localparam int INT_AW          = 5;
  localparam int DIV_STEPS       = 33;

  // configuration register indexes
  localparam logic CFG_HALF_WINDOW     = 1'b0;
  localparam logic CFG_SLOPE_THRESHOLD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDB,
    S_SLOPE_START,
    S_SLOPE_WAIT,
    S_DECIDE,
    S_R1,
    S_R2,
    S_R3,
    S_R4,
    S_CURVE_WAIT,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/sde_ram.sv
`default_nettype none
module sde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/sde_divider.sv
`default_nettype none
module sde_divider (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sde_pkg::div_req_t req,
  output sde_pkg::div_rsp_t    rsp
);
  import sde_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [32:0] nq;
  logic [32:0] dm;
  logic        neg;
  logic [33:0] trial;
  logic        qbit;

  // one restoring step per cycle
  assign trial = {rem, nq[32]};
  assign qbit  = (trial >= {1'b0, dm});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          // zero divisor saturates by sign of numerator
          rsp.done <= 1'b1;
          if (req.num == '0) begin
            rsp.quot <= '0;
          end else if (req.num[32]) begin
            rsp.quot <= 32'sh8000_0000;
          end else begin
            rsp.quot <= 32'sh7FFF_FFFF;
          end
        end else begin
          busy <= 1'b1;
          cnt  <= 6'(DIV_STEPS);
          rem  <= '0;
          nq   <= req.num[32] ? 33'(-req.num) : 33'(req.num);
          dm   <= req.den[32] ? 33'(-req.den) : 33'(req.den);
          neg  <= req.num[32] ^ req.den[32];
        end
      end else if (busy) begin
        if (cnt != '0) begin
          rem <= qbit ? 33'(trial - {1'b0, dm}) : trial[32:0];
          nq  <= {nq[31:0], qbit};
          cnt <= cnt - 6'd1;
        end else begin
          // sign and saturate
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          if (!neg) begin
            rsp.quot <= (nq > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : nq[31:0];
          end else begin
            rsp.quot <= (nq > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-nq[31:0]);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/spectrum_derivative_extrema_unit.sv
`default_nettype none
// Spectrum derivative and extremum unit.
// Input beats on s_* carry one spectrum sample (wavelength, intensity) with
// s_tlast on the final sample. Output beats on m_* carry one result each:
// sample index, first and second central-difference derivatives and the
// extremum, inflection and divide-fault flags; m_tlast marks the final one.
// The cfg channel writes half_window (index 0) and slope_threshold (index 1)
// and is always ready; write it only while no spectrum work is pending.
// One sample is taken at a time; s_tready is high only while idle.
// A sample with at least 2p earlier samples first computes one slope through
// the shared 33-step divider, then each result takes ring reads plus a second
// divide when a second derivative is due. A sample normally gives one result;
// the last sample flushes up to 2p+1 results.
// The shared divider and the single read port of each ring set the rate.
// The result for index j leaves with sample j+2p.
// A stalled m_tready holds the output register and pauses the sequencer.
// Reset (rst, synchronous) clears the sample count, sign history and
// configuration to half_window 1, threshold 0; rings need no clearing.
module spectrum_derivative_extrema_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // wavelength[31:0], intensity[63:32]
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // sample_index[11:0], first_deriv[43:12], second_deriv[75:44],
  // extremum_flag[76], inflection_flag[77], divide_fault[78], zero[79]
  output logic [79:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import sde_pkg::*;

  seq_state_t state, state_next;

  logic [3:0]  half_window;
  logic [30:0] slope_threshold;
  logic [CNT_W-1:0] sample_count;
  logic prev_slope_negative, prev_curve_negative;

  logic [CNT_W-1:0] k, j, hi;
  logic [3:0]  p;
  logic [31:0] w_in;
  logic signed [31:0] x_in;
  logic last_in;
  logic cond1, cond2;
  logic [31:0] wave_hi, wave_lo;
  logic signed [31:0] d1, s_hi;
  logic signed [31:0] d2;
  logic fault;

  logic s_fire, out_free;
  logic [CNT_W-1:0] twop, lo, b;
  logic k_ge;
  logic [3:0] p_eff;

  logic wave_we, int_we, slope_we;
  logic [WAVE_AW-1:0] wave_raddr;
  logic [INT_AW-1:0]  slope_raddr, slope_waddr;
  logic [31:0] wave_rdata, int_rdata, slope_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [32:0] den_now;
  logic [32:0] d1_mag;
  logic neg1, neg2;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_fire    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign p_eff = (half_window == 4'd0) ? 4'd1 : half_window;
  assign twop  = CNT_W'({p, 1'b0});
  assign k_ge  = (k >= twop);
  assign b     = k - twop;
  assign lo    = k_ge ? b : '0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_window     <= 4'd1;
      slope_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HALF_WINDOW:     half_window     <= cfg_data[3:0];
        CFG_SLOPE_THRESHOLD: slope_threshold <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // ring memories
  assign wave_we  = s_fire;
  assign int_we   = s_fire;
  assign slope_we = (state == S_SLOPE_WAIT) && div_rsp.done;
  assign slope_waddr = INT_AW'(k - CNT_W'(p));

  always_comb begin
    wave_raddr  = WAVE_AW'(b);
    slope_raddr = INT_AW'(j);
    unique case (state)
      S_R1: begin
        wave_raddr  = WAVE_AW'(j + CNT_W'(p));
        slope_raddr = INT_AW'(j);
      end
      S_R2: begin
        wave_raddr  = WAVE_AW'(j - CNT_W'(p));
        slope_raddr = INT_AW'(j + CNT_W'(p));
      end
      S_R3: slope_raddr = INT_AW'(j - CNT_W'(p));
      default: ;
    endcase
  end

  sde_ram #(.WIDTH(32), .DEPTH(WAVE_DEPTH)) u_wave_ring (
    .clk(clk), .we(wave_we), .waddr(WAVE_AW'(sample_count)), .wdata(s_tdata[31:0]),
    .raddr(wave_raddr), .rdata(wave_rdata)
  );

  sde_ram #(.WIDTH(32), .DEPTH(INT_DEPTH)) u_intensity_ring (
    .clk(clk), .we(int_we), .waddr(INT_AW'(sample_count)), .wdata(s_tdata[63:32]),
    .raddr(INT_AW'(b)), .rdata(int_rdata)
  );

  sde_ram #(.WIDTH(32), .DEPTH(INT_DEPTH)) u_slope_ring (
    .clk(clk), .we(slope_we), .waddr(slope_waddr), .wdata(div_rsp.quot),
    .raddr(slope_raddr), .rdata(slope_rdata)
  );

  // shared divider requests
  assign den_now = $signed({1'b0, wave_hi}) - $signed({1'b0, wave_lo});

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = $signed({x_in[31], x_in}) - $signed({int_rdata[31], int_rdata});
    div_req.den   = $signed({1'b0, w_in}) - $signed({1'b0, wave_rdata});
    if (state == S_SLOPE_START) begin
      div_req.start = 1'b1;
    end else if (state == S_R4) begin
      div_req.start = cond2;
      div_req.num   = $signed({s_hi[31], s_hi}) - $signed({slope_rdata[31], slope_rdata});
      div_req.den   = den_now;
    end
  end

  sde_divider u_divider (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:        if (s_fire) state_next = S_RDB;
      S_RDB:         state_next = k_ge ? S_SLOPE_START : S_DECIDE;
      S_SLOPE_START: state_next = S_SLOPE_WAIT;
      S_SLOPE_WAIT:  if (div_rsp.done) state_next = S_DECIDE;
      S_DECIDE:      state_next = (last_in || k_ge) ? S_R1 : S_IDLE;
      S_R1:          state_next = S_R2;
      S_R2:          state_next = S_R3;
      S_R3:          state_next = S_R4;
      S_R4:          state_next = cond2 ? S_CURVE_WAIT : S_EMIT;
      S_CURVE_WAIT:  if (div_rsp.done) state_next = S_EMIT;
      S_EMIT: begin
        if (out_free) state_next = (j == hi) ? S_IDLE : S_R1;
      end
      default:       state_next = S_IDLE;
    endcase
  end

  // flag terms of the result being emitted
  assign neg1   = d1[31];
  assign neg2   = d2[31];
  assign d1_mag = neg1 ? 33'(-$signed({d1[31], d1})) : {1'b0, d1};

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count        <= '0;
      prev_slope_negative <= 1'b0;
      prev_curve_negative <= 1'b0;
      m_tvalid            <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            k       <= sample_count;
            p       <= p_eff;
            w_in    <= s_tdata[31:0];
            x_in    <= s_tdata[63:32];
            last_in <= s_tlast || (sample_count >= CNT_W'(MAX_SAMPLES - 1));
          end
        end
        S_DECIDE: begin
          j  <= lo;
          hi <= last_in ? k : lo;
          if (!last_in && !k_ge) begin
            sample_count <= k + CNT_W'(1);
          end
        end
        S_R1: begin
          cond1 <= (j >= CNT_W'(p)) && (j + CNT_W'(p) <= k);
          cond2 <= (j >= twop) && (j + twop <= k);
        end
        S_R2: begin
          wave_hi <= wave_rdata;
          d1      <= cond1 ? slope_rdata : '0;
        end
        S_R3: begin
          wave_lo <= wave_rdata;
          s_hi    <= slope_rdata;
        end
        S_R4: begin
          fault <= cond1 && (den_now == '0);
          d2    <= '0;
        end
        S_CURVE_WAIT: begin
          if (div_rsp.done) d2 <= div_rsp.quot;
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid            <= 1'b1;
            m_tlast             <= last_in && (j == hi);
            m_tdata[11:0]       <= j[IDX_W-1:0];
            m_tdata[43:12]      <= d1;
            m_tdata[75:44]      <= d2;
            m_tdata[76]         <= (j != '0) && (neg1 != prev_slope_negative);
            m_tdata[77]         <= (j != '0) && (neg2 != prev_curve_negative)
                                   && (d1_mag >= {2'b00, slope_threshold});
            m_tdata[78]         <= fault;
            m_tdata[79]         <= 1'b0;
            // sign history restarts after the final result of a spectrum
            prev_slope_negative <= neg1 && !(last_in && (j == hi));
            prev_curve_negative <= neg2 && !(last_in && (j == hi));
            j                   <= j + CNT_W'(1);
            if (j == hi) begin
              if (last_in) begin
                sample_count <= '0;
              end else begin
                sample_count <= k + CNT_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sde_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_SAMPLES = 130;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] d1;
    logic [31:0] d2;
    logic        ext;
    logic        infl;
    logic        fault;
    logic        last;
  } deriv_result_t;

  typedef struct {
    logic [31:0]   wave;
    logic [31:0]   level;
    logic          last;
    bit            typed;
    deriv_result_t want;
  } sample_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  spectrum_derivative_extrema_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // mirror of the block state
  logic [3:0]  hw_reg;
  logic [30:0] thr_reg;
  logic [31:0] wave_hist [WAVE_DEPTH];
  logic [31:0] level_hist [INT_DEPTH];
  logic [31:0] slope_hist [INT_DEPTH];
  bit          slope_was_neg;
  bit          curve_was_neg;
  int unsigned n_seen;

  deriv_result_t pending_results [$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  burst_left;
  int  stall_cnt = 0;
  int  stall_mode = 0;
  bit  hold_typed;
  deriv_result_t typed_result;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // truncating quotient, saturated to 32 bits
  function automatic logic [31:0] sat_quot(longint num, longint den);
    longint q;
    if (den == 0) begin
      if (num > 0) return 32'h7FFF_FFFF;
      if (num < 0) return 32'h8000_0000;
      return 32'd0;
    end
    q = num / den;
    if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -64'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic longint wave_of(int unsigned i);
    return longint'({32'd0, wave_hist[i % WAVE_DEPTH]});
  endfunction

  function automatic deriv_result_t derive_at(int unsigned j, int unsigned k,
                                              int unsigned p, bit last);
    deriv_result_t r;
    longint den, num, mag;
    bit neg1, neg2;
    r.d1 = '0;
    r.d2 = '0;
    r.fault = 1'b0;
    den = 0;
    if (j >= p && j + p <= k) begin
      r.d1 = slope_hist[j % INT_DEPTH];
      den = wave_of(j + p) - wave_of(j - p);
      r.fault = (den == 0);
    end
    if (j >= 2 * p && j + 2 * p <= k) begin
      num = longint'($signed(slope_hist[(j + p) % INT_DEPTH]))
          - longint'($signed(slope_hist[(j - p) % INT_DEPTH]));
      r.d2 = sat_quot(num, den);
    end
    neg1 = r.d1[31];
    neg2 = r.d2[31];
    mag = longint'($signed(r.d1));
    if (mag < 0) mag = -mag;
    r.ext = (j > 0) && (neg1 != slope_was_neg);
    r.infl = (j > 0) && (neg2 != curve_was_neg) && (mag >= longint'({33'd0, thr_reg}));
    slope_was_neg = neg1;
    curve_was_neg = neg2;
    r.idx = j[11:0];
    r.last = last;
    return r;
  endfunction

  // queue the results that one accepted sample releases
  task automatic predict_sample(logic [31:0] w, logic [31:0] x, logic last_in);
    int unsigned k, p, b, lo, hi;
    bit last;
    k = n_seen;
    p = int'(hw_reg);
    if (p < 1) p = 1;
    if (p > MAX_HALF_WINDOW) p = MAX_HALF_WINDOW;
    last = last_in || (k >= MAX_SAMPLES - 1);
    wave_hist[k % WAVE_DEPTH] = w;
    level_hist[k % INT_DEPTH] = x;
    if (k >= 2 * p) begin
      b = k - 2 * p;
      slope_hist[(k - p) % INT_DEPTH] =
        sat_quot(longint'($signed(x)) - longint'($signed(level_hist[b % INT_DEPTH])),
                 longint'({32'd0, w}) - wave_of(b));
    end
    lo = (k >= 2 * p) ? k - 2 * p : 0;
    if (!last && k < 2 * p) begin
      n_seen = k + 1;
      return;
    end
    hi = last ? k : lo;
    for (int unsigned j = lo; j <= hi; j++)
      pending_results.push_back(derive_at(j, k, p, last && j == hi));
    if (last) begin
      n_seen = 0;
      slope_was_neg = 0;
      curve_was_neg = 0;
    end else begin
      n_seen = k + 1;
    end
  endtask

  // one input beat, bursts separated by random gaps
  task automatic send_sample(logic [31:0] w, logic [31:0] x, logic last);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {x, w};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (hold_typed) begin
      predict_sample(w, x, last);
      void'(pending_results.pop_back());
      pending_results.push_back(typed_result);
      hold_typed = 0;
    end else begin
      predict_sample(w, x, last);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one write beat, then the channel is left idle before returning
  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_HALF_WINDOW) hw_reg = value[3:0];
    else thr_reg = value[30:0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // random spectrum with mostly increasing wavelengths
  task automatic send_spectrum(int len);
    logic [31:0] w;
    w = $urandom;
    for (int i = 0; i < len; i++) begin
      send_sample(w, pick_level(), i == len - 1);
      case ($urandom_range(0, 9))
        0: w = w;
        1: w = w - $urandom_range(1, 1000);
        2: w = $urandom;
        default: w = w + $urandom_range(1, 200);
      endcase
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    deriv_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none actual %h", $time, m_tdata);
      end else begin
        e = pending_results.pop_front();
        check_field("sample_index", 32'(e.idx), 32'(m_tdata[11:0]));
        check_field("first_deriv", e.d1, m_tdata[43:12]);
        check_field("second_deriv", e.d2, m_tdata[75:44]);
        check_field("extremum_flag", 32'(e.ext), 32'(m_tdata[76]));
        check_field("inflection_flag", 32'(e.infl), 32'(m_tdata[77]));
        check_field("divide_fault", 32'(e.fault), 32'(m_tdata[78]));
        check_field("pad", 32'd0, 32'(m_tdata[79]));
        check_field("last_result", 32'(e.last), 32'(m_tlast));
      end
    end
  end

  // receiver stall pattern: full speed, random, or sparse
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (stall_cnt % 5 == 0);
    endcase
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  sample_row_t rows [$];
  sample_row_t row;
  int sent;
  int p;

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HALF_WINDOW;
    cfg_data = '0;
    burst_left = 0;
    hold_typed = 0;
    hw_reg = 4'd1;
    thr_reg = '0;
    slope_was_neg = 0;
    curve_was_neg = 0;
    n_seen = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: lone samples, extremes, saturation, zero and negative spans
    row = '{wave: 32'd0, level: 32'd0, last: 1'b1, typed: 1,
            want: '{idx: 12'd0, d1: 32'd0, d2: 32'd0, ext: 0, infl: 0, fault: 0, last: 1}};
    rows.push_back(row);
    row.wave = 32'hFFFF_FFFF;
    row.level = 32'h8000_0000;
    rows.push_back(row);
    row.typed = 0;
    foreach (rows[i]) ;
    begin
      logic [31:0] ws [12];
      logic [31:0] xs [12];
      ws = '{32'd0, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'd5, 32'd6, 32'd7, 32'd7, 32'd3, 32'd4};
      xs = '{32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'hFFFF_FFFB, 32'h0001_0000, 32'd0,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000, 32'd1};
      for (int i = 0; i < 12; i++) begin
        row.wave = ws[i];
        row.level = xs[i];
        row.last = (i == 11);
        rows.push_back(row);
      end
    end
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        hold_typed = 1;
        typed_result = rows[i].want;
      end
      send_sample(rows[i].wave, rows[i].level, rows[i].last);
    end
    drain_results();

    // half window zero behaves as one, threshold at its top
    write_reg(CFG_HALF_WINDOW, 32'd0);
    write_reg(CFG_SLOPE_THRESHOLD, 32'hFFFF_FFFF);
    send_spectrum(9);
    drain_results();

    // widest window, long enough for second derivatives
    write_reg(CFG_HALF_WINDOW, 32'd15);
    write_reg(CFG_SLOPE_THRESHOLD, 32'd0);
    send_spectrum(70);
    drain_results();

    // random phases of settings and spectra
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 4))
        0: write_reg(CFG_HALF_WINDOW, 32'd1);
        1: write_reg(CFG_HALF_WINDOW, 32'd2);
        2: write_reg(CFG_HALF_WINDOW, 32'd15);
        default: write_reg(CFG_HALF_WINDOW, $urandom);
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(CFG_SLOPE_THRESHOLD, 32'd0);
        1: write_reg(CFG_SLOPE_THRESHOLD, 32'h0001_0000);
        2: write_reg(CFG_SLOPE_THRESHOLD, 32'h7FFF_FFFF);
        default: write_reg(CFG_SLOPE_THRESHOLD, $urandom);
      endcase
      p = (hw_reg == 0) ? 1 : int'(hw_reg);
      for (int s = 0; s < 3; s++) begin
        int len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * p)
                                          : $urandom_range(4 * p + 1, 4 * p + 12);
        send_spectrum(len);
        sent += len;
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sde_pkg.sv
design/sde_ram.sv
design/sde_divider.sv
design/spectrum_derivative_extrema_unit.sv
tb/sv/tb_top.sv
